// ----- hw/rtl/cift_pkg.sv -----
package cift_pkg;

   // Field widths of the frame and result beats
   localparam int ID_W      = 11;
   localparam int DATA_W    = 64;
   localparam int COUNT_W   = 32;
   localparam int SLOT_W    = 7;
   localparam int ENTRIES_W = 8;

   // Command codes
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Request beat
   typedef struct packed {
      logic              command;
      logic [ID_W-1:0]   frame_id;
      logic [DATA_W-1:0] frame_data;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [SLOT_W-1:0]    slot;
      logic [ID_W-1:0]      line_id;
      logic [DATA_W-1:0]    line_data;
      logic [COUNT_W-1:0]   line_count;
      logic                 is_new;
      logic                 dropped;
      logic                 overflowed;
      logic [ENTRIES_W-1:0] entries_used;
   } rsp_type;

   // Search token handed from cell to cell
   typedef struct packed {
      logic               valid;
      logic [ID_W-1:0]    id;
      logic [DATA_W-1:0]  data;
      logic               hit;
      logic               is_new;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
   } token_type;

endpackage

// ----- hw/rtl/cift_cell.sv -----
module cift_cell #(
   parameter int CELL_INDEX = 0,
   parameter int USED_W     = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [USED_W-1:0]   used_entries,
   input  cift_pkg::token_type tok_up,
   output cift_pkg::token_type tok_down
);
   import cift_pkg::*;

   localparam logic [USED_W-1:0] CELL_POS  = USED_W'(CELL_INDEX);
   localparam logic [SLOT_W-1:0] CELL_SLOT = SLOT_W'(CELL_INDEX);

   // Entry held by this cell
   logic [ID_W-1:0]    id_ff, id_in;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   token_type          tok_ff, tok_in;

   logic searching;
   logic hit_here;
   logic append_here;

   // Token still looking for its entry
   assign searching   = tok_up.valid && !tok_up.hit && !tok_up.is_new;
   assign hit_here    = searching && (CELL_POS < used_entries) && (id_ff == tok_up.id);
   assign append_here = searching && (CELL_POS == used_entries);

   // Update entry and token
   always_comb begin
      tok_in   = tok_up;
      id_in    = id_ff;
      data_in  = data_ff;
      count_in = count_ff;
      if (hit_here) begin
         data_in       = tok_up.data;
         count_in      = count_ff + COUNT_W'(1);
         tok_in.hit    = 1'b1;
         tok_in.slot   = CELL_SLOT;
         tok_in.count  = count_in;
      end else if (append_here) begin
         id_in         = tok_up.id;
         data_in       = tok_up.data;
         count_in      = COUNT_W'(1);
         tok_in.is_new = 1'b1;
         tok_in.slot   = CELL_SLOT;
         tok_in.count  = count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      data_ff  <= data_in;
      count_ff <= count_in;
   end

   // Token stage toward the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_down = tok_ff;

endmodule

// ----- hw/rtl/can_id_frame_table_top.sv -----
// A frame beat launches a search token that walks the row of TABLE_DEPTH cells one cell
// per cycle; its result then passes the done register and the output register. No new beat
// is taken until that result has moved to the output register; a clear beat does not hold it.
// Reset empties the table and clears the overflow flag; entry contents are not cleared,
// since only entries below the fill count are ever searched.
module can_id_frame_table_top #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cift_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cift_pkg::rsp_type rsp_payload
);
   import cift_pkg::*;

   localparam int USED_W = $clog2(TABLE_DEPTH + 1);

   token_type tok_chain [TABLE_DEPTH+1];
   token_type tok_launch;
   token_type tok_exit;

   logic [USED_W-1:0] used_ff, used_in;
   logic              overflow_ff, overflow_in;
   logic              busy_ff, busy_in;
   logic              done_valid_ff, done_valid_in;
   rsp_type           done_ff, done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic req_beat;
   logic move_done;
   logic found;

   assign req_stall = busy_ff;
   assign req_beat  = req_valid && !busy_ff;
   assign move_done = done_valid_ff && (!rsp_valid_ff || !rsp_stall);

   // Launch token for a frame beat
   always_comb begin
      tok_launch        = '0;
      tok_launch.valid  = req_beat && (req_payload.command == CMD_FRAME);
      tok_launch.id     = req_payload.frame_id;
      tok_launch.data   = req_payload.frame_data;
   end

   assign tok_chain[0] = tok_launch;

   // Row of table cells
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      cift_cell #(
         .CELL_INDEX (g),
         .USED_W     (USED_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .used_entries (used_ff),
         .tok_up       (tok_chain[g]),
         .tok_down     (tok_chain[g+1])
      );
   end

   assign tok_exit = tok_chain[TABLE_DEPTH];
   assign found    = tok_exit.hit || tok_exit.is_new;

   // Table bookkeeping and result assembly
   always_comb begin
      used_in       = used_ff;
      overflow_in   = overflow_ff;
      busy_in       = busy_ff;
      done_valid_in = done_valid_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (req_beat) begin
         if (req_payload.command == CMD_CLEAR) begin
            used_in = '0;
         end else begin
            busy_in = 1'b1;
         end
      end

      if (tok_exit.valid) begin
         if (tok_exit.is_new) begin
            used_in = used_ff + USED_W'(1);
         end
         if (!found) begin
            overflow_in = 1'b1;
         end
         done_valid_in        = 1'b1;
         done_in.slot         = found ? tok_exit.slot : '0;
         done_in.line_id      = found ? tok_exit.id : '0;
         done_in.line_data    = found ? tok_exit.data : '0;
         done_in.line_count   = found ? tok_exit.count : '0;
         done_in.is_new       = tok_exit.is_new;
         done_in.dropped      = !found;
         done_in.overflowed   = overflow_in;
         done_in.entries_used = ENTRIES_W'(used_in);
      end

      // Output register
      if (move_done) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = done_ff;
         done_valid_in = 1'b0;
         busy_in       = 1'b0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         overflow_ff   <= 1'b0;
         busy_ff       <= 1'b0;
         done_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         used_ff       <= used_in;
         overflow_ff   <= overflow_in;
         busy_ff       <= busy_in;
         done_valid_ff <= done_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= done_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- bench/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cift_pkg::*;

   localparam int TABLE_DEPTH   = 128;
   localparam int RANDOM_FRAMES = 1200;
   localparam int IDLE_PCT      = 9;
   // window of cycles with no idling on either side
   localparam int QUIET_FROM    = 40000;
   localparam int QUIET_TO      = 70000;

   typedef struct {
      req_type beat;
      bit      drain;   // hold this beat until all results are back
   } pending_beat_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   pending_beat_type pending_beats[$];
   rsp_type       expected_lines[$];
   int            sent_beats     = 0;
   int            accepted_beats = 0;
   int            cycle_count    = 0;
   int            mismatches     = 0;

   // shadow copy of the identifier table
   logic [ID_W-1:0]    shadow_id    [TABLE_DEPTH];
   logic [DATA_W-1:0]  shadow_data  [TABLE_DEPTH];
   logic [COUNT_W-1:0] shadow_count [TABLE_DEPTH];
   int                 shadow_used     = 0;
   logic               shadow_overflow = 1'b0;

   can_id_frame_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Apply one beat to the shadow table; returns 1 when a line is produced
   function automatic bit update_shadow_table(input req_type beat, output rsp_type line);
      int hit_slot;
      line = '0;
      hit_slot = -1;
      if (beat.command == CMD_CLEAR) begin
         shadow_used = 0;
         return 1'b0;
      end
      for (int i = 0; i < shadow_used; i++) begin
         if (hit_slot < 0 && shadow_id[i] == beat.frame_id) hit_slot = i;
      end
      if (hit_slot >= 0) begin
         shadow_data[hit_slot]  = beat.frame_data;
         shadow_count[hit_slot] = shadow_count[hit_slot] + 1'b1;
         line.slot       = SLOT_W'(hit_slot);
         line.line_id    = shadow_id[hit_slot];
         line.line_data  = shadow_data[hit_slot];
         line.line_count = shadow_count[hit_slot];
      end else if (shadow_used >= TABLE_DEPTH) begin
         // table full: frame discarded, flag sticks until reset
         shadow_overflow = 1'b1;
         line.dropped    = 1'b1;
      end else begin
         shadow_id[shadow_used]    = beat.frame_id;
         shadow_data[shadow_used]  = beat.frame_data;
         shadow_count[shadow_used] = 1;
         line.slot       = SLOT_W'(shadow_used);
         line.line_id    = beat.frame_id;
         line.line_data  = beat.frame_data;
         line.line_count = 1;
         line.is_new     = 1'b1;
         shadow_used++;
      end
      line.overflowed   = shadow_overflow;
      line.entries_used = ENTRIES_W'(shadow_used);
      return 1'b1;
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
         mismatches++;
      end
   endfunction

   function automatic void queue_beat(logic cmd, logic [ID_W-1:0] id,
                                      logic [DATA_W-1:0] data, bit drain = 1'b0);
      pending_beat_type item;
      item.beat.command    = cmd;
      item.beat.frame_id   = id;
      item.beat.frame_data = data;
      item.drain           = drain;
      pending_beats.push_back(item);
   endfunction

   function automatic logic [DATA_W-1:0] random_data();
      return {$urandom, $urandom};
   endfunction

   function automatic bit quiet_window();
      return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
   endfunction

   // Driver: a new beat goes out only once the previous one was taken
   always @(negedge clock) begin
      bit may_send;
      may_send = 1'b0;
      if (!reset && (!req_valid || accepted_beats == sent_beats)) begin
         if (pending_beats.size() != 0 &&
             (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT) &&
             (!pending_beats[0].drain || expected_lines.size() == 0)) begin
            may_send = 1'b1;
         end
         if (may_send) begin
            req_payload <= pending_beats[0].beat;
            req_valid   <= 1'b1;
            pending_beats.pop_front();
            sent_beats++;
         end else begin
            req_valid <= 1'b0;
         end
      end
      if (!reset) begin
         rsp_stall <= !quiet_window() && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Monitor: check result beats, then record accepted request beats
   always @(posedge clock) begin
      rsp_type want;
      rsp_type line;
      if (!reset) begin
         cycle_count++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines.size() == 0) begin
               $error("result beat with no frame outstanding: slot %0d id 'h%0h",
                      rsp_payload.slot, rsp_payload.line_id);
               mismatches++;
            end else begin
               want = expected_lines.pop_front();
               check_field("slot", 64'(want.slot), 64'(rsp_payload.slot));
               check_field("line_id", 64'(want.line_id), 64'(rsp_payload.line_id));
               check_field("line_data", 64'(want.line_data), 64'(rsp_payload.line_data));
               check_field("line_count", 64'(want.line_count), 64'(rsp_payload.line_count));
               check_field("is_new", 64'(want.is_new), 64'(rsp_payload.is_new));
               check_field("dropped", 64'(want.dropped), 64'(rsp_payload.dropped));
               check_field("overflowed", 64'(want.overflowed), 64'(rsp_payload.overflowed));
               check_field("entries_used", 64'(want.entries_used),
                           64'(rsp_payload.entries_used));
            end
         end
         if (req_valid && !req_stall) begin
            accepted_beats++;
            if (update_shadow_table(req_payload, line)) expected_lines.push_back(line);
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int frames;
      int kind;
      int seq;
      int len;
      int pool;
      logic [ID_W-1:0] base;

      // directed: field extremes, hits, clears with junk fields
      queue_beat(CMD_FRAME, 11'h000, 64'h0);
      queue_beat(CMD_FRAME, 11'h7FF, '1);
      queue_beat(CMD_FRAME, 11'h000, 64'h0123_4567_89AB_CDEF);
      queue_beat(CMD_FRAME, 11'h7FF, 64'h0);
      queue_beat(CMD_FRAME, 11'h555, 64'h5555_5555_5555_5555);
      queue_beat(CMD_FRAME, 11'h2AA, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_beat(CMD_FRAME, 11'h2AA, 64'h0000_0000_FFFF_FFFF);
      queue_beat(CMD_FRAME, 11'h2AA, 64'hFFFF_FFFF_0000_0000);
      queue_beat(CMD_FRAME, 11'h555, '1);
      queue_beat(CMD_CLEAR, 11'h7FF, '1);
      queue_beat(CMD_FRAME, 11'h7FF, '1);
      queue_beat(CMD_FRAME, 11'h000, 64'h8000_0000_0000_0001);
      queue_beat(CMD_CLEAR, 11'h000, 64'h0);
      queue_beat(CMD_CLEAR, 11'h555, 64'h5555_5555_5555_5555);
      queue_beat(CMD_FRAME, 11'h400, 64'h0000_0000_0000_0080);
      queue_beat(CMD_FRAME, 11'h001, 64'h0100_0000_0000_0000);
      queue_beat(CMD_FRAME, 11'h400, 64'h0);

      // random: mostly pooled bursts, plus sweeps that fill the table and clears
      frames = 0;
      seq    = 0;
      while (frames < RANDOM_FRAMES) begin
         kind = (seq == 0) ? 0 : $urandom_range(0, 99);
         if (kind < 20) begin
            // clear, fill to at least the depth, then revisit the same ids, which hit or drop
            base = ID_W'($urandom_range(0, 2047));
            len  = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 8);
            queue_beat(CMD_CLEAR, ID_W'($urandom), random_data(), 1'b1);
            for (int k = 0; k < len; k++) begin
               queue_beat(CMD_FRAME, base + ID_W'(k), random_data());
            end
            repeat ($urandom_range(2, 8)) begin
               queue_beat(CMD_FRAME, base + ID_W'($urandom_range(0, len - 1)), random_data());
               frames++;
            end
            frames += len;
         end else if (kind < 30) begin
            queue_beat(CMD_CLEAR, ID_W'($urandom), random_data(), kind < 23);
         end else begin
            // burst drawn from a pool of up to 200 ids, often with repeats
            base = ID_W'($urandom_range(0, 2047));
            pool = $urandom_range(1, 200);
            len  = $urandom_range(10, 120);
            for (int k = 0; k < len; k++) begin
               queue_beat(CMD_FRAME, base + ID_W'($urandom_range(0, pool - 1)), random_data());
            end
            frames += len;
         end
         seq++;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_valid) @(posedge clock);
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 20) @(posedge clock);

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(20_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/cift_pkg.sv
hw/rtl/cift_cell.sv
hw/rtl/can_id_frame_table_top.sv
bench/tb.sv
